/* design/pgw_pkg.sv */
package pgw_pkg;

  localparam int GRID_DIM  = 32;
  localparam int MAX_STEPS = 255;
  localparam int HEADINGS  = 4;

  localparam int POS_W     = 5;
  localparam int CNT_W     = 8;
  localparam int HEAD_W    = 2;
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
  localparam int ADDR_W    = $clog2(GRID_CELLS);

  typedef enum logic [2:0] {
    OP_PEN_UP   = 3'd0,
    OP_PEN_DOWN = 3'd1,
    OP_TURN_R   = 3'd2,
    OP_TURN_L   = 3'd3,
    OP_MOVE     = 3'd4,
    OP_READ     = 3'd5
  } pgw_op_e;

  localparam logic [HEAD_W-1:0] HD_EAST  = 2'd0;
  localparam logic [HEAD_W-1:0] HD_SOUTH = 2'd1;
  localparam logic [HEAD_W-1:0] HD_WEST  = 2'd2;
  localparam logic [HEAD_W-1:0] HD_NORTH = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOVE,
    ST_READ,
    ST_DONE
  } pgw_state_e;

  typedef struct packed {
    logic [2:0]       operation;
    logic [CNT_W-1:0] move_count;
    logic [POS_W-1:0] cell_row;
    logic [POS_W-1:0] cell_col;
  } pgw_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_row;
    logic [POS_W-1:0]  pos_col;
    logic [HEAD_W-1:0] heading;
    logic              pen_is_down;
    logic              cell_value;
    logic              hit_edge;
  } pgw_out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pgw_mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
    cell_addr = ADDR_W'(int'(row) * GRID_DIM + int'(col));
  endfunction

endpackage

/* design/pgw_grid_ram.sv */
module pgw_grid_ram import pgw_pkg::*; (
  input  logic         clk,
  input  pgw_mem_req_t mem_req,
  output logic         rd_data
);

  logic mem [GRID_CELLS];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/pgw_walker.sv */
module pgw_walker import pgw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  pgw_in_t      in_data,
  output logic         res_valid,
  input  logic         res_ready,
  output pgw_out_t     res_data,
  output pgw_mem_req_t mem_req,
  input  logic         rd_data
);

  pgw_state_e        state_r, state_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic              pen_r, pen_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cell_r, cell_nxt;
  logic              edge_r, edge_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  steps;
  logic              blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r   <= '0;
      col_r   <= '0;
      head_r  <= HD_EAST;
      pen_r   <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      head_r  <= head_nxt;
      pen_r   <= pen_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    cell_r  <= cell_nxt;
    edge_r  <= edge_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  // clip before the step counter loads
  always_comb begin
    if (int'(in_data.move_count) > MAX_STEPS) begin
      steps = CNT_W'(MAX_STEPS);
    end else begin
      steps = in_data.move_count;
    end
  end

  always_comb begin
    case (head_r)
      HD_EAST:  blocked = (int'(col_r) + 1 >= GRID_DIM);
      HD_SOUTH: blocked = (int'(row_r) + 1 >= GRID_DIM);
      HD_WEST:  blocked = (col_r == '0);
      default:  blocked = (row_r == '0);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    head_nxt  = head_r;
    pen_nxt   = pen_r;
    cnt_nxt   = cnt_r;
    cell_nxt  = cell_r;
    edge_nxt  = edge_r;
    rd_ok_nxt = rd_ok_r;
    clr_nxt   = clr_r;
    mem_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = 1'b0;
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == ADDR_W'(GRID_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cell_nxt  = 1'b0;
          edge_nxt  = 1'b0;
          state_nxt = ST_DONE;
          case (in_data.operation)
            OP_PEN_UP:   pen_nxt  = 1'b0;
            OP_PEN_DOWN: pen_nxt  = 1'b1;
            OP_TURN_R:   head_nxt = HEAD_W'((int'(head_r) + 1) % HEADINGS);
            OP_TURN_L:   head_nxt = HEAD_W'((int'(head_r) + HEADINGS - 1) % HEADINGS);
            OP_MOVE: begin
              if (steps != '0) begin
                cnt_nxt   = steps;
                state_nxt = ST_MOVE;
              end
            end
            OP_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = cell_addr(in_data.cell_row, in_data.cell_col);
              rd_ok_nxt     = (int'(in_data.cell_row) < GRID_DIM) &&
                              (int'(in_data.cell_col) < GRID_DIM);
              state_nxt     = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_MOVE: begin
        // mark the cell we stand on if the pen is down, then step, or stop at the border or after the last step
        mem_req.we    = pen_r;
        mem_req.waddr = cell_addr(row_r, col_r);
        mem_req.wdata = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (blocked) begin
          edge_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          case (head_r)
            HD_EAST:  col_nxt = col_r + 1'b1;
            HD_SOUTH: row_nxt = row_r + 1'b1;
            HD_WEST:  col_nxt = col_r - 1'b1;
            default:  row_nxt = row_r - 1'b1;
          endcase
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        cell_nxt  = rd_ok_r & rd_data;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res_data.pos_row     = row_r;
  assign res_data.pos_col     = col_r;
  assign res_data.heading     = head_r;
  assign res_data.pen_is_down = pen_r;
  assign res_data.cell_value  = cell_r;
  assign res_data.hit_edge    = edge_r;

endmodule

/* design/pen_plotter_grid_walker.sv */
// Sequence: pen and turn words go from idle to the done state, a read via the read
// state, a move via one move state per step (the walker writes a cell while pen down).
// Flow: one word at a time; next word accepted the cycle after the result leaves
// the walker, while the output register may still be holding the previous result.
// Reset: synchronous, active low; then a clearing pass sweeps all 1024 grid RAM cells
// one cell a cycle, with in_ready low until it ends.
module pen_plotter_grid_walker import pgw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pgw_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pgw_out_t out_data
);

  pgw_mem_req_t mem_req;
  logic         rd_data;
  logic         res_valid;
  logic         res_ready;
  pgw_out_t     res_data;

  logic         out_valid_r;
  pgw_out_t     out_data_r;

  // grid store: one bit per cell, single write and read port
  pgw_grid_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // command sequencer: pen state, heading, position and step counter
  pgw_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // output register: the slot frees when empty or drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
